// ===== rtl/core/lcdw_pkg.sv =====
`timescale 1ns / 1ps

package lcdw_pkg;

    // Request kinds as they arrive on the input channel.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CMD   = 2'd1;
    localparam logic [1:0] KIND_INIT  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_DELAY     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_SETTLE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_SETTLE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTE_GAP        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAKE_FIRST_WAIT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WAKE_NEXT_WAIT  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [15:0] PULSE_DELAY_RST     = 16'd20;
    localparam logic [15:0] DATA_SETTLE_RST     = 16'd2000;
    localparam logic [15:0] COMMAND_SETTLE_RST  = 16'd120;
    localparam logic [15:0] BYTE_GAP_RST        = 16'd1000;
    localparam logic [15:0] WAKE_FIRST_WAIT_RST = 16'd7000;
    localparam logic [15:0] WAKE_NEXT_WAIT_RST  = 16'd480;

    // Controller command bytes.
    localparam logic [7:0] CMD_WAKE       = 8'h30;
    localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME_LINE  = 8'h80;
    localparam logic [7:0] CMD_CURSOR     = 8'h10;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

    localparam int unsigned WAIT_W = 18;

    // Byte sequence of the power-up init request.
    localparam logic [7:0] INIT_SEQ [8] = '{
        CMD_WAKE, CMD_WAKE, CMD_WAKE, CMD_FUNC_4BIT,
        CMD_CLEAR, CMD_HOME_LINE, CMD_CURSOR, CMD_ENTRY_MODE
    };
    localparam logic [2:0] INIT_LAST_BYTE  = 3'd7;
    localparam logic [2:0] CLEAR_LAST_BYTE = 3'd1;
    localparam logic [2:0] ONE_LAST_BYTE   = 3'd0;

    // Default depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        JOB_DATA,
        JOB_CMD,
        JOB_INIT,
        JOB_CLEAR
    } job_kind_t;

    // One classified request as queued for the back end.
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] value;
        logic [2:0] last_byte;
    } job_t;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] pulse_delay;
        logic [15:0] data_settle;
        logic [15:0] command_settle;
        logic [15:0] byte_gap;
        logic [15:0] wake_first_wait;
        logic [15:0] wake_next_wait;
    } cfg_t;

    // Byte number idx of the sequence that a request sends.
    function automatic logic [7:0] seq_byte(input job_t job, input logic [2:0] idx);
        logic [7:0] b;
        b = job.value;
        unique case (job.kind)
            JOB_DATA, JOB_CMD: b = job.value;
            JOB_CLEAR:         b = idx[0] ? CMD_HOME_LINE : CMD_CLEAR;
            JOB_INIT:          b = INIT_SEQ[idx];
            default:           b = job.value;
        endcase
        return b;
    endfunction

    // A 16-bit count plus one, widened to the wait width.
    function automatic logic [WAIT_W-1:0] count_plus_one(input logic [15:0] c);
        return {{(WAIT_W-16){1'b0}}, c} + {{(WAIT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// ===== rtl/core/lcdw_front.sv =====
`timescale 1ns / 1ps

module lcdw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [7:0]        byte_value,
    output logic              push,
    output lcdw_pkg::job_t    push_job,
    input  logic              q_ready
);
    import lcdw_pkg::*;

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;
    logic load;

    // The holding register takes a request when empty or when it is pushed on.
    assign push     = valid_reg && q_ready;
    assign load     = !valid_reg || push;
    assign in_stall = !load;
    assign push_job = job_reg;

    // Classify the request into a job with its sequence length.
    always_comb
    begin
        job_next = job_reg;
        unique case (kind)
            KIND_DATA:
            begin
                job_next.kind      = JOB_DATA;
                job_next.value     = byte_value;
                job_next.last_byte = ONE_LAST_BYTE;
            end
            KIND_CMD:
            begin
                job_next.kind      = JOB_CMD;
                job_next.value     = byte_value;
                job_next.last_byte = ONE_LAST_BYTE;
            end
            KIND_INIT:
            begin
                job_next.kind      = JOB_INIT;
                job_next.value     = 8'h00;
                job_next.last_byte = INIT_LAST_BYTE;
            end
            default:
            begin
                job_next.kind      = JOB_CLEAR;
                job_next.value     = 8'h00;
                job_next.last_byte = CLEAR_LAST_BYTE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded with each accepted request.
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== rtl/core/lcdw_queue.sv =====
`timescale 1ns / 1ps

module lcdw_queue #(
    parameter int unsigned DEPTH = lcdw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lcdw_pkg::job_t    push_job,
    output logic              q_ready,
    input  logic              pop,
    output logic              q_valid,
    output lcdw_pkg::job_t    head_job
);
    import lcdw_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t              mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign q_ready  = count_reg != CNT_FULL;
    assign q_valid  = count_reg != '0;
    assign head_job = mem[rd_ptr_reg];
    assign do_push  = push && q_ready;
    assign do_pop   = pop && q_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/core/lcdw_back.sv =====
`timescale 1ns / 1ps

module lcdw_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lcdw_pkg::cfg_t               cfg,
    input  logic                         q_valid,
    input  lcdw_pkg::job_t               head_job,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [3:0]                   bus_nibble,
    output logic                         reg_select,
    output logic                         enable_line,
    output logic [lcdw_pkg::WAIT_W-1:0]  wait_ticks,
    output logic                         last_event
);
    import lcdw_pkg::*;

    typedef enum logic [1:0] {
        PH_SETUP,
        PH_HIGH,
        PH_LOW
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic               nib_reg;
    logic               nib_next;
    logic [2:0]         idx_reg;
    logic [2:0]         idx_next;
    logic               pre_done_reg;
    logic               pre_done_next;
    logic [3:0]         held_nibble_reg;
    logic [3:0]         held_nibble_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [3:0]         nibble_reg;
    logic               select_reg;
    logic               enable_reg;
    logic [WAIT_W-1:0]  wait_reg;
    logic               last_reg;

    logic               advance;
    logic               emit;
    logic               is_init;
    logic               is_pre;
    logic               byte_end;
    logic [7:0]         cur_byte;
    logic [3:0]         ev_nibble;
    logic               ev_select;
    logic               ev_enable;
    logic [WAIT_W-1:0]  ev_wait;
    logic               ev_last;
    logic [WAIT_W-1:0]  base_wait;
    logic [WAIT_W-1:0]  gap_wait;
    logic [WAIT_W-1:0]  wake_wait;

    // The output register moves on when empty or when its request is taken.
    assign advance = !out_valid_reg || !out_stall;
    assign emit    = advance && q_valid;
    assign pop     = emit && ev_last;

    assign out_valid   = out_valid_reg;
    assign bus_nibble  = nibble_reg;
    assign reg_select  = select_reg;
    assign enable_line = enable_reg;
    assign wait_ticks  = wait_reg;
    assign last_event  = last_reg;

    // Build the pin event for the current position in the head job.
    always_comb
    begin
        is_init   = head_job.kind == JOB_INIT;
        is_pre    = is_init && !pre_done_reg;
        cur_byte  = seq_byte(head_job, idx_reg);
        byte_end  = (phase_reg == PH_LOW) && nib_reg;
        ev_select = head_job.kind == JOB_DATA;

        base_wait = (phase_reg == PH_LOW)
                  ? count_plus_one(ev_select ? cfg.data_settle : cfg.command_settle)
                  : count_plus_one(cfg.pulse_delay);
        gap_wait  = byte_end ? count_plus_one(cfg.byte_gap) : '0;
        wake_wait = '0;
        if (byte_end && is_init)
        begin
            if (idx_reg == 3'd0)
            begin
                wake_wait = count_plus_one(cfg.wake_first_wait);
            end
            else if (idx_reg == 3'd1 || idx_reg == 3'd2)
            begin
                wake_wait = count_plus_one(cfg.wake_next_wait);
            end
        end

        if (is_pre)
        begin
            // Init opens by dropping select and enable on the held nibble.
            ev_nibble = held_nibble_reg;
            ev_select = 1'b0;
            ev_enable = 1'b0;
            ev_wait   = '0;
            ev_last   = 1'b0;
        end
        else
        begin
            ev_nibble = nib_reg ? cur_byte[3:0] : cur_byte[7:4];
            ev_enable = phase_reg == PH_HIGH;
            ev_wait   = base_wait + gap_wait + wake_wait;
            ev_last   = byte_end && (idx_reg == head_job.last_byte);
        end
    end

    // Step through phases, nibbles and bytes of the head job.
    always_comb
    begin
        phase_next       = phase_reg;
        nib_next         = nib_reg;
        idx_next         = idx_reg;
        pre_done_next    = pre_done_reg;
        held_nibble_next = held_nibble_reg;
        out_valid_next   = out_valid_reg;
        if (advance)
        begin
            out_valid_next = q_valid;
        end
        if (emit)
        begin
            held_nibble_next = ev_nibble;
            if (is_pre)
            begin
                pre_done_next = 1'b1;
            end
            else if (ev_last)
            begin
                phase_next    = PH_SETUP;
                nib_next      = 1'b0;
                idx_next      = '0;
                pre_done_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SETUP: phase_next = PH_HIGH;
                    PH_HIGH:  phase_next = PH_LOW;
                    PH_LOW:
                    begin
                        phase_next = PH_SETUP;
                        nib_next   = !nib_reg;
                        if (nib_reg)
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    default:  phase_next = PH_SETUP;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SETUP;
            nib_reg         <= 1'b0;
            idx_reg         <= '0;
            pre_done_reg    <= 1'b0;
            held_nibble_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            nib_reg         <= nib_next;
            idx_reg         <= idx_next;
            pre_done_reg    <= pre_done_next;
            held_nibble_reg <= held_nibble_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            nibble_reg <= ev_nibble;
            select_reg <= ev_select;
            enable_reg <= ev_enable;
            wait_reg   <= ev_wait;
            last_reg   <= ev_last;
        end
    end

endmodule

// ===== rtl/core/char_lcd_nibble_write_sequencer_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in        in_valid, in_stall   kind, byte_value
// out       out_valid, out_stall bus_nibble, reg_select, enable_line, wait_ticks, last_event
// cfg       cfg_write            cfg_index, cfg_data
//
// The back sequencer emits one pin event per cycle unless stalled: setup, high
// and low events per nibble, one more to open an init; it sets the sustained
// rate. An accepted request passes through the front register and the queue to
// the output register. Reset clears all control state and loads the
// configuration defaults. Either side may stall; the queue decouples them.

module char_lcd_nibble_write_sequencer_top #(
    parameter int unsigned QUEUE_DEPTH = lcdw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          kind,
    input  logic [7:0]                          byte_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [3:0]                          bus_nibble,
    output logic                                reg_select,
    output logic                                enable_line,
    output logic [lcdw_pkg::WAIT_W-1:0]         wait_ticks,
    output logic                                last_event,
    input  logic                                cfg_write,
    input  logic [lcdw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [15:0]                         cfg_data
);
    import lcdw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic push;
    job_t push_job;
    logic q_ready;
    logic pop;
    logic q_valid;
    job_t head_job;

    // Configuration register writes; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PULSE_DELAY:     cfg_next.pulse_delay     = cfg_data;
                REG_DATA_SETTLE:     cfg_next.data_settle     = cfg_data;
                REG_COMMAND_SETTLE:  cfg_next.command_settle  = cfg_data;
                REG_BYTE_GAP:        cfg_next.byte_gap        = cfg_data;
                REG_WAKE_FIRST_WAIT: cfg_next.wake_first_wait = cfg_data;
                REG_WAKE_NEXT_WAIT:  cfg_next.wake_next_wait  = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_delay     <= PULSE_DELAY_RST;
            cfg_reg.data_settle     <= DATA_SETTLE_RST;
            cfg_reg.command_settle  <= COMMAND_SETTLE_RST;
            cfg_reg.byte_gap        <= BYTE_GAP_RST;
            cfg_reg.wake_first_wait <= WAKE_FIRST_WAIT_RST;
            cfg_reg.wake_next_wait  <= WAKE_NEXT_WAIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accepts and classifies requests.
    lcdw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .byte_value (byte_value),
        .push       (push),
        .push_job   (push_job),
        .q_ready    (q_ready)
    );

    // Job queue between front and back.
    lcdw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_job (head_job)
    );

    // Back end: expands jobs into pin events.
    lcdw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bus_nibble  (bus_nibble),
        .reg_select  (reg_select),
        .enable_line (enable_line),
        .wait_ticks  (wait_ticks),
        .last_event  (last_event)
    );

`ifndef SYNTHESIS
    // An enable-high event is always followed at once by its enable-low event.
    a_strobe_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && enable_line) |=> (out_valid && !enable_line))
        else $error("enable high event not followed by enable low event");

    // The final event of a request never leaves enable high.
    a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_event) |-> !enable_line)
        else $error("final event with enable high");

    // Only the init opening event carries a zero wait.
    a_zero_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wait_ticks == '0) |-> (!enable_line && !reg_select && !last_event))
        else $error("zero wait on a strobe event");

    // The back end only retires a job that is present in the queue.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue pop while empty");
`endif

endmodule
